// ----- rtl/xpf_pkg.sv -----
// shared constants, burst type and crc step for the xmodem packet framer
`default_nettype none

package xpf_pkg;

    localparam int DATA_BYTES  = 1024;
    localparam int SLOT_W      = $clog2(DATA_BYTES);
    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0]  HDR_START = 8'h02;
    localparam logic [7:0]  PAD_BYTE  = 8'hFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [IDX_W-1:0] IDX_HEADER = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CRC    = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_DATA   = IDX_W'(0);

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [IDX_W-1:0]            last_idx;
        logic                        crc_end;
    } xpf_burst_t;

    // crc-16/xmodem over one byte, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/xpf_serializer.sv -----
// result register that holds one burst of framed bytes and sends them out one by one
`default_nettype none

module xpf_serializer
    import xpf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load_valid,
    input  wire xpf_burst_t load_burst,
    output logic            load_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_packet_done,
    output logic            m_last_of_run
);

    logic             full_reg;
    logic [IDX_W-1:0] idx_reg;
    xpf_burst_t       burst_reg;
    logic             at_last;

    assign at_last    = (idx_reg == burst_reg.last_idx);
    assign load_ready = !full_reg || (m_ready && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load_valid && load_ready) begin
            full_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (full_reg && m_ready) begin
            if (at_last) begin
                full_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            burst_reg <= load_burst;
        end
    end

    assign m_valid       = full_reg;
    assign m_out_byte    = burst_reg.bytes[idx_reg];
    assign m_last_of_run = at_last;
    assign m_packet_done = at_last && burst_reg.crc_end;

endmodule

`default_nettype wire

// ----- rtl/xmodem_packet_framer_top.sv -----
// top level of the xmodem-1k packet framer with crc-16
//
// s_ channel: one transaction per data slot, s_data_byte with s_byte_present;
// a slot with s_byte_present low is filled with the pad byte 0xff.
// m_ channel: one framed byte per transaction. the first slot of a packet
// gives four bytes (stx, packet number, its complement, data), the last slot
// gives three (data, crc high, crc low with m_packet_done), any other slot one.
// m_last_of_run marks the final byte caused by a slot.
// cfg channel: cfg_data sets the packet number of the first packet; written
// before the first packet it also numbers that packet. cfg_ready is always high.
// latency: the first byte of a slot is on m_ from the cycle after acceptance.
// throughput: one slot per cycle on ordinary slots while m_ready is high; a header
// slot holds the output register until its four bytes are taken and a crc slot
// until its three, as the output sends one byte per cycle when m_ready is high. s_ready
// is high whenever the result register is empty or its last byte is being taken.
// reset: slot counter and crc cleared, packet number set to 1.
// when the receiver stalls, the held byte stays and s_ready drops once a burst waits.
`default_nettype none

module xmodem_packet_framer_top
    import xpf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_byte_present,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_packet_done,
    output logic            m_last_of_run,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic [SLOT_W-1:0] slot_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        pkt_reg;
    logic              started_reg;

    logic              accept;
    logic              load_ready;
    logic [7:0]        slot_byte;
    logic              first_slot;
    logic              last_slot;
    logic [15:0]       crc_next;
    xpf_burst_t        burst;

    assign cfg_ready  = 1'b1;
    assign s_ready    = load_ready;
    assign accept     = s_valid && load_ready;
    assign slot_byte  = s_byte_present ? s_data_byte : PAD_BYTE;
    assign first_slot = (slot_reg == '0);
    assign last_slot  = (slot_reg == SLOT_W'(DATA_BYTES - 1));
    assign crc_next   = crc_feed(first_slot ? 16'h0000 : crc_reg, slot_byte);

    always_comb begin
        burst          = '0;
        burst.crc_end  = last_slot;
        if (first_slot) begin
            burst.bytes[0] = HDR_START;
            burst.bytes[1] = pkt_reg;
            burst.bytes[2] = ~pkt_reg;
            burst.bytes[3] = slot_byte;
            burst.last_idx = IDX_HEADER;
        end else if (last_slot) begin
            burst.bytes[0] = slot_byte;
            burst.bytes[1] = crc_next[15:8];
            burst.bytes[2] = crc_next[7:0];
            burst.last_idx = IDX_CRC;
        end else begin
            burst.bytes[0] = slot_byte;
            burst.last_idx = IDX_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            crc_reg       <= '0;
            pkt_reg       <= 8'd1;
            started_reg   <= 1'b0;
        end else begin
            if (accept) begin
                started_reg <= 1'b1;
                if (last_slot) begin
                    slot_reg <= '0;
                    crc_reg  <= '0;
                    pkt_reg  <= pkt_reg + 8'd1;
                end else begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                    crc_reg  <= crc_next;
                end
            end
            if (cfg_valid && !started_reg) begin
                pkt_reg <= cfg_data;
            end
        end
    end

    xpf_serializer u_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load_valid    (s_valid),
        .load_burst    (burst),
        .load_ready    (load_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_packet_done (m_packet_done),
        .m_last_of_run (m_last_of_run)
    );

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_done |-> m_last_of_run)
        else $error("packet done without end of run");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted slot produced no result");

    a_header_first: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && first_slot |=> m_out_byte == HDR_START && !m_last_of_run)
        else $error("packet does not open with stx");

    a_started_once: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> started_reg)
        else $error("started flag not set after a slot");

endmodule

`default_nettype wire
